[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Concurrent assertion on the standard clk_i / rst_ni pair.
`define ASSERT_CLK(name, prop) `ASSERT_AT(name, clk_i, rst_ni, prop)

`endif

[rtl/npp_pkg.sv]
// Types and constants of the null bitmap page planner.
// No dependencies; imported by every module of the block.
package npp_pkg;

  localparam int unsigned ROW_W      = 17;
  localparam int unsigned BYTE_IDX_W = 14;
  localparam int unsigned POP_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned STATUS_W   = 3;

  localparam logic [BYTE_IDX_W-1:0] BYTE_IDX_MAX = '1;
  localparam int unsigned CNT_CEIL = 131071;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OFS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_CNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_NULLS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NULLS_PADDED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ARG   = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_OOB       = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_CAP_SHORT = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NO_NULLS  = 3'd4;

  typedef struct packed {
    logic [7:0] bitmap_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          validity_bits;
    logic [7:0]          window_mask;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [ROW_W-1:0]    physical_offset;
    logic [ROW_W-1:0]    physical_count;
  } out_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] total_rows;
    logic [15:0]      window_offset;
    logic [ROW_W-1:0] window_count;
    logic             has_nulls;
    logic             nulls_padded;
    logic             lsb_first;
    logic [ROW_W-1:0] validity_capacity;
  } cfg_t;

  // Per-byte evaluation handed to the chunk state
  typedef struct packed {
    logic [7:0]       validity_bits;
    logic [7:0]       window_mask;
    logic             null_hit;
    logic [POP_W-1:0] n_before;
    logic [POP_W-1:0] n_in;
  } eval_t;

endpackage

[rtl/npp_byte_eval.sv]
// Per-byte row evaluation: validity, window mask, non-null counts.
// Depends on npp_pkg.
module npp_byte_eval (
  input  logic [7:0]                     bitmap_byte_i,
  input  logic [npp_pkg::BYTE_IDX_W-1:0] byte_idx_i,
  input  npp_pkg::cfg_t                  cfg_i,
  output npp_pkg::eval_t                 eval_o
);
  import npp_pkg::*;

  function automatic logic [POP_W-1:0] popcount8(input logic [7:0] v);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + POP_W'(v[i]);
    end
    return c;
  endfunction

  logic [ROW_W-1:0] win_start;
  logic [ROW_W-1:0] win_end;
  logic [7:0]       valid_bits;
  logic [7:0]       mask_bits;
  logic [7:0]       null_hits;
  logic [7:0]       before_bits;
  logic [7:0]       inwin_bits;

  assign win_start = ROW_W'(cfg_i.window_offset);
  assign win_end   = win_start + cfg_i.window_count;

  for (genvar k = 0; k < 8; k++) begin : g_bit
    logic [ROW_W-1:0] row;
    logic             null_bit;
    logic             in_win;
    logic             live;

    assign row      = {byte_idx_i, 3'(k)};
    assign null_bit = cfg_i.has_nulls &
                      (cfg_i.lsb_first ? bitmap_byte_i[k] : bitmap_byte_i[7-k]);
    assign in_win   = (row >= win_start) & (row < win_end);
    // padding rows past the chunk end are neither valid nor null
    assign live     = row < cfg_i.total_rows;

    assign valid_bits[k]  = live & ~null_bit;
    assign mask_bits[k]   = in_win;
    assign null_hits[k]   = live & null_bit;
    assign before_bits[k] = valid_bits[k] & (row < win_start);
    assign inwin_bits[k]  = valid_bits[k] & in_win;
  end

  assign eval_o.validity_bits = valid_bits;
  assign eval_o.window_mask   = mask_bits;
  assign eval_o.null_hit      = |null_hits;
  assign eval_o.n_before      = popcount8(before_bits);
  assign eval_o.n_in          = popcount8(inwin_bits);

endmodule

[rtl/npp_chunk_state.sv]
// Chunk state: byte index, saturating non-null counters, null flag, and
// the final status and physical range on the last byte. Depends on npp_pkg.
module npp_chunk_state #(
  parameter int unsigned CNT_LIM = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  logic                           last_i,
  input  npp_pkg::cfg_t                  cfg_i,
  input  npp_pkg::eval_t                 eval_i,
  output logic [npp_pkg::BYTE_IDX_W-1:0] byte_idx_o,
  output logic [npp_pkg::STATUS_W-1:0]   status_o,
  output logic [npp_pkg::ROW_W-1:0]      phys_off_o,
  output logic [npp_pkg::ROW_W-1:0]      phys_cnt_o
);
  import npp_pkg::*;

  localparam int unsigned     CNT_W = $clog2(CNT_LIM + 1);
  localparam logic [CNT_W-1:0] LIM  = CNT_W'(CNT_LIM);

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [POP_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(c) + (CNT_W+1)'(n);
    return (s > (CNT_W+1)'(CNT_LIM)) ? LIM : s[CNT_W-1:0];
  endfunction

  logic [BYTE_IDX_W-1:0] byte_idx_q;
  logic [CNT_W-1:0]      before_q, before_d;
  logic [CNT_W-1:0]      inwin_q, inwin_d;
  logic                  null_seen_q, null_seen_d;

  logic [ROW_W-1:0]      win_end;
  logic [BYTE_IDX_W:0]   bytes_seen;
  logic [BYTE_IDX_W:0]   bytes_need;
  logic [STATUS_W-1:0]   status;

  assign before_d    = sat_add(before_q, eval_i.n_before);
  assign inwin_d     = sat_add(inwin_q, eval_i.n_in);
  assign null_seen_d = null_seen_q | eval_i.null_hit;

  assign win_end    = ROW_W'(cfg_i.window_offset) + cfg_i.window_count;
  assign bytes_seen = {1'b0, byte_idx_q} + (BYTE_IDX_W+1)'(1);
  assign bytes_need = (BYTE_IDX_W+1)'(((ROW_W+1)'(cfg_i.total_rows) + (ROW_W+1)'(7)) >> 3);

  always_comb begin
    status = STATUS_OK;
    if (cfg_i.total_rows == '0 || cfg_i.window_count == '0) begin
      status = STATUS_BAD_ARG;
    end else if (win_end > cfg_i.total_rows) begin
      status = STATUS_OOB;
    end else if (cfg_i.window_count > cfg_i.validity_capacity) begin
      status = STATUS_CAP_SHORT;
    end else if (cfg_i.has_nulls && bytes_seen != bytes_need) begin
      status = STATUS_BAD_ARG;
    end else if (cfg_i.has_nulls && !null_seen_d) begin
      status = STATUS_NO_NULLS;
    end
  end

  always_comb begin
    status_o   = STATUS_OK;
    phys_off_o = '0;
    phys_cnt_o = '0;
    if (last_i) begin
      status_o = status;
      if (status == STATUS_OK) begin
        if (cfg_i.has_nulls && !cfg_i.nulls_padded) begin
          phys_off_o = ROW_W'(before_d);
          phys_cnt_o = ROW_W'(inwin_d);
        end else begin
          phys_off_o = ROW_W'(cfg_i.window_offset);
          phys_cnt_o = cfg_i.window_count;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q  <= '0;
      before_q    <= '0;
      inwin_q     <= '0;
      null_seen_q <= 1'b0;
    end else if (advance_i) begin
      if (last_i) begin
        // clear for the next chunk
        byte_idx_q  <= '0;
        before_q    <= '0;
        inwin_q     <= '0;
        null_seen_q <= 1'b0;
      end else begin
        before_q    <= before_d;
        inwin_q     <= inwin_d;
        null_seen_q <= null_seen_d;
        if (byte_idx_q != BYTE_IDX_MAX) begin
          byte_idx_q <= byte_idx_q + BYTE_IDX_W'(1);
        end
      end
    end
  end

  assign byte_idx_o = byte_idx_q;

endmodule

[rtl/null_bitmap_page_planner.sv]
// Null bitmap page planner top level: config registers, input and output
// registers. Depends on npp_pkg, npp_byte_eval, npp_chunk_state.
//
// Usage:
//   Write the configuration through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while the block is idle, then stream the null bitmap of one column chunk
//   on the input channel, one byte per transaction, last_byte set on the
//   final byte. Each input transaction yields exactly one output transaction
//   with the validity bits and page window mask of that byte's eight rows;
//   the result of the last byte also carries status and the physical range.
//   Path: a transaction accepted on the input channel is captured by the input
//   register, then by the result register, which drives the output.
//   Throughput: one byte per cycle while the receiver does not stall; the
//   per-byte row tests, popcounts and counter update all sit between the two registers.
//   Reset clears the pipeline and the chunk counters and restores the
//   register defaults (lsb_first 1, validity_capacity 65536, others 0).
//   When the receiver stalls, the result register holds its transaction, the
//   input register fills, and in_ready_o drops until out_ready_i returns.
module null_bitmap_page_planner #(
  parameter int unsigned MAX_ROWS = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [npp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [npp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  npp_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output npp_pkg::out_item_t             out_data_o
);
  import npp_pkg::*;

  localparam int unsigned CNT_LIM = (MAX_ROWS > CNT_CEIL) ? CNT_CEIL : MAX_ROWS;

  cfg_t       cfg_q;
  logic       in_valid_q;
  in_item_t   in_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       out_load;
  logic       advance;

  logic [BYTE_IDX_W-1:0] byte_idx;
  eval_t                 eval;
  logic [STATUS_W-1:0]   status;
  logic [ROW_W-1:0]      phys_off;
  logic [ROW_W-1:0]      phys_cnt;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_rows        <= '0;
      cfg_q.window_offset     <= '0;
      cfg_q.window_count      <= '0;
      cfg_q.has_nulls         <= 1'b0;
      cfg_q.nulls_padded      <= 1'b0;
      cfg_q.lsb_first         <= 1'b1;
      cfg_q.validity_capacity <= ROW_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TOTAL_ROWS:   cfg_q.total_rows        <= cfg_wdata_i;
        REG_WINDOW_OFS:   cfg_q.window_offset     <= cfg_wdata_i[15:0];
        REG_WINDOW_CNT:   cfg_q.window_count      <= cfg_wdata_i;
        REG_HAS_NULLS:    cfg_q.has_nulls         <= cfg_wdata_i[0];
        REG_NULLS_PADDED: cfg_q.nulls_padded      <= cfg_wdata_i[0];
        REG_LSB_FIRST:    cfg_q.lsb_first         <= cfg_wdata_i[0];
        REG_CAPACITY:     cfg_q.validity_capacity <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: advance moves a transaction into the result register
  assign out_load   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_load;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  npp_byte_eval u_eval (
    .bitmap_byte_i (in_q.bitmap_byte),
    .byte_idx_i    (byte_idx),
    .cfg_i         (cfg_q),
    .eval_o        (eval)
  );

  npp_chunk_state #(
    .CNT_LIM (CNT_LIM)
  ) u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .last_i     (in_q.last_byte),
    .cfg_i      (cfg_q),
    .eval_i     (eval),
    .byte_idx_o (byte_idx),
    .status_o   (status),
    .phys_off_o (phys_off),
    .phys_cnt_o (phys_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.validity_bits   <= eval.validity_bits;
      out_q.window_mask     <= eval.window_mask;
      out_q.done_res        <= in_q.last_byte;
      out_q.status          <= status;
      out_q.physical_offset <= phys_off;
      out_q.physical_count  <= phys_cnt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/npp_port_checker.sv]
// Port-level checks on the planner's result channel, bound to the top level.
// Depends on npp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module npp_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input npp_pkg::out_item_t out_data_i
);
  import npp_pkg::*;

  // a stalled result transaction holds
  `ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))

  // intermediate bytes carry no status or range
  `ASSERT_CLK(a_mid_zero, out_valid_i && !out_data_i.done_res |-> out_data_i.status == STATUS_OK && out_data_i.physical_offset == '0 && out_data_i.physical_count == '0)

  // an error drops the physical range
  `ASSERT_CLK(a_err_zero, out_valid_i && out_data_i.status != STATUS_OK |-> out_data_i.physical_offset == '0 && out_data_i.physical_count == '0)

  // only defined status codes leave the block
  `ASSERT_CLK(a_status_def, out_valid_i |-> out_data_i.status == STATUS_OK || out_data_i.status == STATUS_BAD_ARG || out_data_i.status == STATUS_OOB || out_data_i.status == STATUS_CAP_SHORT || out_data_i.status == STATUS_NO_NULLS)

endmodule

bind null_bitmap_page_planner npp_port_checker u_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// Testbench for null_bitmap_page_planner: streams null bitmaps with random handshake
// gaps and compares every result against a cycle-free predictor of the block.
// Depends on npp_pkg and the RTL of the block.
module testbench;
  import npp_pkg::*;

  localparam int unsigned MAX_ROWS     = 65536;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned MAX_PRINTS   = 100;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam longint unsigned TIMEOUT_NS = 64'd60_000_000;

  typedef enum int unsigned {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_SPARSE} fill_e;

  class page_plan_scoreboard;
    cfg_t                  regs;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [ROW_W-1:0]      nonnull_before;
    logic [ROW_W-1:0]      nonnull_in;
    logic                  null_seen;
    out_item_t             plan_q[$];
    int unsigned           errors;
    int unsigned           printed;

    function new();
      regs = '0;
      regs.lsb_first = 1'b1;
      regs.validity_capacity = 17'd65536;
      clear_chunk();
      errors = 0;
      printed = 0;
    endfunction

    function void clear_chunk();
      byte_idx = '0;
      nonnull_before = '0;
      nonnull_in = '0;
      null_seen = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TOTAL_ROWS:   regs.total_rows = data;
        REG_WINDOW_OFS:   regs.window_offset = data[15:0];
        REG_WINDOW_CNT:   regs.window_count = data;
        REG_HAS_NULLS:    regs.has_nulls = data[0];
        REG_NULLS_PADDED: regs.nulls_padded = data[0];
        REG_LSB_FIRST:    regs.lsb_first = data[0];
        REG_CAPACITY:     regs.validity_capacity = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return plan_q.size();
    endfunction

    // Evaluate the eight rows of one accepted byte and queue the result.
    function void note_byte(in_item_t item);
      out_item_t   res;
      int unsigned row;
      int unsigned win_end;
      int unsigned lim;
      int unsigned used;
      int unsigned need;
      int unsigned sel;
      logic        is_null;
      res = '0;
      lim = (MAX_ROWS < CNT_CEIL) ? MAX_ROWS : CNT_CEIL;
      win_end = regs.window_offset + regs.window_count;
      for (int k = 0; k < 8; k++) begin
        row = {byte_idx, 3'b000} + k;
        sel = regs.lsb_first ? k : 7 - k;
        is_null = regs.has_nulls && item.bitmap_byte[sel];
        if (row >= regs.window_offset && row < win_end) res.window_mask[k] = 1'b1;
        // padding rows past the chunk neither count nor mark a null
        if (row < regs.total_rows) begin
          if (is_null) begin
            null_seen = 1'b1;
          end else begin
            res.validity_bits[k] = 1'b1;
            if (row < regs.window_offset) begin
              if (nonnull_before < lim) nonnull_before++;
            end else if (row < win_end) begin
              if (nonnull_in < lim) nonnull_in++;
            end
          end
        end
      end
      if (item.last_byte) begin
        used = byte_idx + 1;
        need = (regs.total_rows + 7) / 8;
        res.done_res = 1'b1;
        if (regs.total_rows == 0 || regs.window_count == 0) begin
          res.status = STATUS_BAD_ARG;
        end else if (win_end > regs.total_rows) begin
          res.status = STATUS_OOB;
        end else if (regs.window_count > regs.validity_capacity) begin
          res.status = STATUS_CAP_SHORT;
        end else if (regs.has_nulls && used != need) begin
          res.status = STATUS_BAD_ARG;
        end else if (regs.has_nulls && !null_seen) begin
          res.status = STATUS_NO_NULLS;
        end else begin
          res.status = STATUS_OK;
          if (regs.has_nulls && !regs.nulls_padded) begin
            res.physical_offset = nonnull_before;
            res.physical_count = nonnull_in;
          end else begin
            res.physical_offset = regs.window_offset;
            res.physical_count = regs.window_count;
          end
        end
        clear_chunk();
      end else if (byte_idx != BYTE_IDX_MAX) begin
        byte_idx++;
      end
      plan_q.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (printed < MAX_PRINTS) begin
        printed++;
        $display("%0t ns: mismatch: %s", $time, what);
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (plan_q.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = plan_q.pop_front();
      // validity of the final byte means nothing once the chunk failed
      if (got.validity_bits !== want.validity_bits &&
          !(want.done_res && want.status != STATUS_OK))
        report($sformatf("validity_bits got %h expected %h",
                         got.validity_bits, want.validity_bits));
      if (got.window_mask !== want.window_mask)
        report($sformatf("window_mask got %h expected %h",
                         got.window_mask, want.window_mask));
      if (got.done_res !== want.done_res)
        report($sformatf("done_res got %b expected %b", got.done_res, want.done_res));
      if (got.status !== want.status)
        report($sformatf("status got %0d expected %0d", got.status, want.status));
      if (got.physical_offset !== want.physical_offset)
        report($sformatf("physical_offset got %0d expected %0d",
                         got.physical_offset, want.physical_offset));
      if (got.physical_count !== want.physical_count)
        report($sformatf("physical_count got %0d expected %0d",
                         got.physical_count, want.physical_count));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;

  page_plan_scoreboard plan;
  bit                  quiet;
  bit                  hold_req;

  null_bitmap_page_planner #(.MAX_ROWS(MAX_ROWS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] gen_byte(fill_e style);
    case (style)
      FILL_ZERO:   return 8'h00;
      FILL_ONES:   return 8'hFF;
      FILL_SPARSE: return ($urandom_range(0, 7) == 0) ? 8'h01 << $urandom_range(0, 7) : 8'h00;
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic fill_e pick_fill();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return FILL_ZERO;
    if (r < 20) return FILL_ONES;
    if (r < 70) return FILL_RANDOM;
    return FILL_SPARSE;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    plan.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned rows, int unsigned ofs, int unsigned cnt,
                            bit nulls, bit padded, bit lsb, int unsigned cap);
    logic junk;
    junk = 1'($urandom_range(0, 1));
    write_reg(REG_TOTAL_ROWS, CFG_DATA_W'(rows));
    // the unused top bit of the offset write must be dropped
    write_reg(REG_WINDOW_OFS, {junk, ofs[15:0]});
    write_reg(REG_WINDOW_CNT, CFG_DATA_W'(cnt));
    write_reg(REG_HAS_NULLS, CFG_DATA_W'(nulls));
    write_reg(REG_NULLS_PADDED, CFG_DATA_W'(padded));
    write_reg(REG_LSB_FIRST, CFG_DATA_W'(lsb));
    write_reg(REG_CAPACITY, CFG_DATA_W'(cap));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_byte(logic [7:0] data, logic is_last);
    in_item_t    item;
    int unsigned gap;
    item.bitmap_byte = data;
    item.last_byte = is_last;
    gap = 0;
    if (!quiet && $urandom_range(0, 9) < 4) gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    plan.note_byte(item);
  endtask

  task automatic send_chunk(int unsigned nbytes, fill_e style);
    for (int unsigned i = 0; i < nbytes; i++) send_byte(gen_byte(style), i == nbytes - 1);
  endtask

  // Hold the input idle until every queued result has been checked.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (plan.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_chunk(output int unsigned nbytes);
    int unsigned r;
    int unsigned rows;
    int unsigned ofs;
    int unsigned cnt;
    int unsigned cap;
    int unsigned need;
    r = $urandom_range(0, 99);
    if (r < 4) rows = 0;
    else if (r < 10) rows = $urandom_range(97, 65536);
    else rows = $urandom_range(1, 96);
    r = $urandom_range(0, 99);
    if (r < 10) ofs = $urandom_range(0, 65535);
    else ofs = $urandom_range(0, rows) & 16'hFFFF;
    r = $urandom_range(0, 99);
    if (r < 8) cnt = 0;
    else if (r < 16) cnt = $urandom_range(0, 65536);
    else if (ofs < rows) cnt = $urandom_range(1, rows - ofs) + ((r < 24) ? 1 : 0);
    else cnt = $urandom_range(0, 3);
    if (cnt > 65536) cnt = 65536;
    r = $urandom_range(0, 99);
    if (r < 15) cap = $urandom_range(0, cnt);
    else if (r < 30) cap = cnt;
    else cap = 65536;
    need = (rows + 7) / 8;
    if (need == 0) nbytes = $urandom_range(1, 3);
    else if (need <= 12 && $urandom_range(0, 99) < 80) nbytes = need;
    else nbytes = $urandom_range(1, (need < 12) ? need + 2 : 12);
    set_config(rows, ofs, cnt, $urandom_range(0, 99) < 80, $urandom_range(0, 1) == 1,
               $urandom_range(0, 1) == 1, cap);
    quiet = ($urandom_range(0, 4) == 0);
    send_chunk(nbytes, pick_fill());
    drain();
  endtask

  initial begin : receiver
    int unsigned stall;
    stall = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 9) < 3) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) plan.check_result(out_data_o);
  end

  initial begin : stimulus
    int unsigned done_items;
    int unsigned nbytes;
    int unsigned chunks;
    plan = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: zero rows is an invalid argument
    send_byte(8'hFF, 1'b1);
    drain();
    set_config(8, 0, 8, 1, 0, 1, 65536);
    send_byte(8'h00, 1'b1);
    send_byte(8'h5A, 1'b1);
    drain();
    set_config(8, 2, 5, 1, 0, 0, 65536);
    send_byte(8'h0F, 1'b1);
    drain();
    set_config(8, 2, 5, 1, 1, 0, 65536);
    send_byte(8'hF0, 1'b1);
    drain();
    // padding rows in the last byte, then a bitmap one byte short
    set_config(20, 3, 10, 1, 0, 1, 10);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h81, 1'b1);
    drain();
    set_config(20, 15, 10, 1, 0, 1, 65536);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h04, 1'b1);
    drain();
    set_config(20, 3, 10, 1, 1, 1, 0);
    send_byte(8'hFF, 1'b1);
    drain();
    // nulls absent: bytes ignored, no size check
    set_config(20, 0, 20, 0, 0, 1, 65536);
    send_byte(8'hFF, 1'b1);
    drain();
    set_config(20, 0, 0, 1, 0, 1, 65536);
    send_byte(8'h3C, 1'b1);
    drain();
    set_config(65536, 65535, 1, 1, 0, 0, 65536);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    drain();
    set_config(1, 0, 1, 1, 0, 1, 1);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h01, 1'b1);
    drain();

    done_items = 0;
    chunks = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (chunks == 3 || chunks == 15) begin
        // stall the output long enough to back the input up
        set_config(192, 40, 100, 1, 0, 1, 65536);
        quiet = 1'b1;
        hold_req = 1'b1;
        send_chunk(24, FILL_RANDOM);
        drain();
        nbytes = 24;
      end else begin
        random_chunk(nbytes);
      end
      done_items += nbytes;
      chunks++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (plan.errors == 0 && plan.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
